@@ hw/rtl/hbc_pkg.sv @@
package hbc_pkg;

    localparam int SLOT_COUNT   = 64;
    localparam int SLOT_IDX_W   = $clog2(SLOT_COUNT);
    localparam int COORD_W      = 10;
    localparam int TIME_W       = 48;
    localparam int LABEL_W      = 32;
    localparam int SLOT_FIELD_W = 6;
    localparam int TWIN_W       = 16;
    localparam int MARGIN_W     = 8;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIME_WINDOW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MARGIN  = CFG_IDX_W'(1);

    localparam logic [TWIN_W-1:0]   TIME_WINDOW_RST = TWIN_W'(75);
    localparam logic [MARGIN_W-1:0] BOX_MARGIN_RST  = MARGIN_W'(1);

    typedef struct packed {
        logic [COORD_W-1:0] hit_x;
        logic [COORD_W-1:0] hit_y;
        logic [TIME_W-1:0]  hit_time;
    } hit_t;

    typedef struct packed {
        logic [LABEL_W-1:0]      cluster_label;
        logic                    opened_cluster;
        logic [SLOT_FIELD_W-1:0] slot_used;
    } result_t;

    // search token walking down the row of slots
    typedef struct packed {
        logic                  valid;
        logic                  found;
        logic                  opened;
        logic [LABEL_W-1:0]    label;
        logic [SLOT_IDX_W-1:0] idx;
        logic [TIME_W-1:0]     oldest_time;
        logic [SLOT_IDX_W-1:0] oldest_idx;
    } tok_t;

    // hit and settings seen by every slot at once
    typedef struct packed {
        hit_t                  hit;
        logic [TWIN_W-1:0]     time_window;
        logic [MARGIN_W-1:0]   box_margin;
        logic                  evict_en;
        logic [SLOT_IDX_W-1:0] evict_idx;
        logic [LABEL_W-1:0]    evict_label;
    } bcast_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_LAUNCH,
        ST_WALK,
        ST_FINISH
    } state_t;

endpackage

@@ hw/rtl/hit_box_clusterer_top.sv @@
// Box-search clusterer: each hit (x, y, time) gets the label of a cluster slot.
// One hit is in flight at a time; the input is ready again once the result
// has moved into the output register, and a stalled output holds the input
// off until the result register frees. A search token walks the row of slot
// cells one cell per cycle, picking the first empty or matching slot and
// tracking the oldest start time on the way; when no slot matches, the oldest
// one is reused with a fresh label at the end of the walk. The result sits in
// an output register. time_window (index 0) and box_margin (index 1) are
// written through the cfg port; the user must write them only while no hit is
// pending, the block itself does not enforce this. Writes to other indexes are
// dropped.
module hit_box_clusterer_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  hbc_pkg::hit_t                    s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output hbc_pkg::result_t                 m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hbc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import hbc_pkg::*;

    bcast_t                bcast;
    tok_t                  tok [0:SLOT_COUNT];
    logic [SLOT_COUNT-1:0] took_vec;

    hbc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bcast     (bcast),
        .tok_head  (tok[0]),
        .tok_tail  (tok[SLOT_COUNT])
    );

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        hbc_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_index (SLOT_IDX_W'(g)),
            .bcast      (bcast),
            .tok_in     (tok[g]),
            .tok_out    (tok[g+1]),
            .took       (took_vec[g])
        );
    end

    a_single_take: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(took_vec))
        else $error("more than one slot took the item");

    a_take_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (|took_vec) |=> !(|took_vec))
        else $error("slot taken twice for one item");

    a_evict_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        bcast.evict_en |-> (tok[SLOT_COUNT].valid && !tok[SLOT_COUNT].found))
        else $error("eviction although a slot took the item");

    a_walk_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        tok[SLOT_COUNT].valid |-> !s_ready)
        else $error("input ready while search in progress");

endmodule

@@ hw/rtl/hbc_cell.sv @@
module hbc_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [hbc_pkg::SLOT_IDX_W-1:0]   cell_index,
    input  hbc_pkg::bcast_t                  bcast,
    input  hbc_pkg::tok_t                    tok_in,
    output hbc_pkg::tok_t                    tok_out,
    output logic                             took
);
    import hbc_pkg::*;

    logic                  valid_reg;
    logic [COORD_W-1:0]    x_lo_reg, x_hi_reg, y_lo_reg, y_hi_reg;
    logic [TIME_W-1:0]     start_reg;
    logic [LABEL_W-1:0]    label_reg;
    logic                  match_reg;
    logic                  match_next;
    tok_t                  tok_reg;
    tok_t                  tok_next;

    logic [TIME_W:0]       t_ext, st_ext, w_ext;
    logic                  time_ok;
    logic [COORD_W:0]      x_ext, y_ext, m_ext;
    logic                  box_ok;
    logic                  take;
    logic                  evict_here;

    // window test without wrap: st - w <= t <= st + w
    always_comb begin
        t_ext   = {1'b0, bcast.hit.hit_time};
        st_ext  = {1'b0, start_reg};
        w_ext   = (TIME_W+1)'(bcast.time_window);
        time_ok = (t_ext <= st_ext + w_ext) && (st_ext <= t_ext + w_ext);
        x_ext   = {1'b0, bcast.hit.hit_x};
        y_ext   = {1'b0, bcast.hit.hit_y};
        m_ext   = (COORD_W+1)'(bcast.box_margin);
        box_ok  = (x_ext + m_ext >= {1'b0, x_lo_reg}) &&
                  (x_ext <= {1'b0, x_hi_reg} + m_ext) &&
                  (y_ext + m_ext >= {1'b0, y_lo_reg}) &&
                  (y_ext <= {1'b0, y_hi_reg} + m_ext);
        match_next = time_ok && box_ok;
    end

    always_comb begin
        take       = tok_in.valid && !tok_in.found && (!valid_reg || match_reg);
        evict_here = bcast.evict_en && (bcast.evict_idx == cell_index);
        tok_next   = tok_in;
        if (start_reg < tok_in.oldest_time) begin
            tok_next.oldest_time = start_reg;
            tok_next.oldest_idx  = cell_index;
        end
        if (take) begin
            tok_next.found  = 1'b1;
            tok_next.opened = !valid_reg;
            tok_next.label  = label_reg;
            tok_next.idx    = cell_index;
        end
    end

    always_ff @(posedge aclk) begin
        match_reg <= match_next;
        if (evict_here || (take && !valid_reg)) begin
            x_lo_reg  <= bcast.hit.hit_x;
            x_hi_reg  <= bcast.hit.hit_x;
            y_lo_reg  <= bcast.hit.hit_y;
            y_hi_reg  <= bcast.hit.hit_y;
            start_reg <= bcast.hit.hit_time;
        end else if (take) begin
            if (bcast.hit.hit_x < x_lo_reg) x_lo_reg <= bcast.hit.hit_x;
            if (bcast.hit.hit_x > x_hi_reg) x_hi_reg <= bcast.hit.hit_x;
            if (bcast.hit.hit_y < y_lo_reg) y_lo_reg <= bcast.hit.hit_y;
            if (bcast.hit.hit_y > y_hi_reg) y_hi_reg <= bcast.hit.hit_y;
        end
        if (!aresetn) begin
            valid_reg <= 1'b0;
            label_reg <= LABEL_W'(cell_index);
            tok_reg   <= '0;
        end else begin
            tok_reg <= tok_next;
            if (evict_here || take) valid_reg <= 1'b1;
            if (evict_here) label_reg <= bcast.evict_label;
        end
    end

    assign tok_out = tok_reg;
    assign took    = take;

endmodule

@@ hw/rtl/hbc_ctrl.sv @@
module hbc_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  hbc_pkg::hit_t                    s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output hbc_pkg::result_t                 m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hbc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output hbc_pkg::bcast_t                  bcast,
    output hbc_pkg::tok_t                    tok_head,
    input  hbc_pkg::tok_t                    tok_tail
);
    import hbc_pkg::*;

    state_t              state_reg, state_next;
    hit_t                hit_reg;
    logic [TWIN_W-1:0]   tw_reg;
    logic [MARGIN_W-1:0] bm_reg;
    logic [LABEL_W-1:0]  counter_reg, counter_next;
    result_t             res_reg, res_next;
    result_t             m_data_reg, m_data_next;
    logic                m_valid_reg, m_valid_next;
    logic                evict_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            counter_reg <= LABEL_W'(SLOT_COUNT);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            counter_reg <= counter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        if (s_valid && s_ready) hit_reg <= s_data;
        if (!aresetn) begin
            tw_reg <= TIME_WINDOW_RST;
            bm_reg <= BOX_MARGIN_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TIME_WINDOW: tw_reg <= cfg_data;
                REG_BOX_MARGIN:  bm_reg <= cfg_data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        counter_next = counter_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        evict_en     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_MATCH;
            end
            // slots settle their match flags against the new hit
            ST_MATCH:  state_next = ST_LAUNCH;
            ST_LAUNCH: state_next = ST_WALK;
            ST_WALK: begin
                if (tok_tail.valid) begin
                    state_next = ST_FINISH;
                    if (tok_tail.found) begin
                        res_next.cluster_label  = tok_tail.label;
                        res_next.opened_cluster = tok_tail.opened;
                        res_next.slot_used      = SLOT_FIELD_W'(tok_tail.idx);
                    end else begin
                        evict_en                = 1'b1;
                        res_next.cluster_label  = counter_reg;
                        res_next.opened_cluster = 1'b1;
                        res_next.slot_used      = SLOT_FIELD_W'(tok_tail.oldest_idx);
                        counter_next            = counter_reg + LABEL_W'(1);
                    end
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        bcast.hit         = hit_reg;
        bcast.time_window = tw_reg;
        bcast.box_margin  = bm_reg;
        bcast.evict_en    = evict_en;
        bcast.evict_idx   = tok_tail.oldest_idx;
        bcast.evict_label = counter_reg;

        tok_head             = '0;
        tok_head.valid       = (state_reg == ST_LAUNCH);
        tok_head.oldest_time = '1;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule
